[rtl/integer_sorting_store_assert.svh]
// Assertion macros shared by the sorting store.
`ifndef INTEGER_SORTING_STORE_ASSERT_SVH
`define INTEGER_SORTING_STORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISS_ASSERT_NOW(lbl, clock, rst_n, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorting store assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ISS_ASSERT_NEXT(lbl, clock, rst_n, ante, cons) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorting store assertion failed");

`endif

[rtl/iss_pkg.sv]
package iss_pkg;

	localparam int CAPACITY = 256;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	localparam logic ACTION_LOAD   = 1'b0;
	localparam logic ACTION_UNLOAD = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic load;
		logic unload;
	} cell_ctrl_t;

endpackage

[rtl/integer_sorting_store.sv]
// Sorting store for signed 32-bit values, built as a row of 256 cells kept in
// ascending order.
// A command is transferred at a rising edge where start is high and busy is low.
// Action 0 loads value_in, action 1 unloads the smallest value still held.
// Busy is never raised: every cell updates in the cycle of the transfer, so one
// command is taken on every clock cycle, limited only by the compare against value_in
// and the neighbour-to-neighbour shift in the cell row.
// Each command gives exactly one result, shown on value_out, status and last_out
// for one cycle with done high, in the cycle after the command was transferred.
// Status 0 is success, 1 a load dropped because the store is full, and 2 an
// unload from an empty store; value_out is zero unless an unload succeeded.
// Last_out marks the unload that leaves the store empty.
// The receiver cannot hold results off; it must take each one as it appears.
// Reset empties the store at once, without a clearing pass, and no result is
// pending afterwards.
module integer_sorting_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              action,
	input  logic signed [iss_pkg::DATA_W-1:0] value_in,
	output logic                              done,
	output logic signed [iss_pkg::DATA_W-1:0] value_out,
	output logic [1:0]                        status,
	output logic                              last_out
);

	logic [iss_pkg::CNT_W-1:0]         fill_q;
	logic                              done_q;
	logic signed [iss_pkg::DATA_W-1:0] value_out_q;
	logic [1:0]                        status_q;
	logic                              last_q;

	logic                              accept;
	logic                              full;
	logic                              empty;
	logic                              last_unload;
	logic                              full_load;
	iss_pkg::cell_ctrl_t               ctrl;

	logic                              ge [iss_pkg::CAPACITY];
	logic signed [iss_pkg::DATA_W-1:0] cell_value [iss_pkg::CAPACITY];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (fill_q == iss_pkg::CNT_W'(iss_pkg::CAPACITY));
	assign empty  = (fill_q == '0);

	assign ctrl.load   = accept && (action == iss_pkg::ACTION_LOAD) && !full;
	assign ctrl.unload = accept && (action == iss_pkg::ACTION_UNLOAD) && !empty;

	assign last_unload = ctrl.unload && (fill_q == iss_pkg::CNT_W'(1));
	assign full_load   = accept && (action == iss_pkg::ACTION_LOAD) && full;

	for (genvar i = 0; i < iss_pkg::CAPACITY; i++) begin : g_cell
		logic                              occ;
		logic                              left_ge;
		logic signed [iss_pkg::DATA_W-1:0] left_value;
		logic signed [iss_pkg::DATA_W-1:0] right_value;

		assign occ = (iss_pkg::CNT_W'(i) < fill_q);

		if (i == 0) begin : g_first
			assign left_ge    = 1'b0;
			assign left_value = value_in;
		end else begin : g_inner
			assign left_ge    = ge[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == iss_pkg::CAPACITY - 1) begin : g_last
			assign right_value = cell_value[i];
		end else begin : g_body
			assign right_value = cell_value[i+1];
		end

		iss_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (occ),
			.new_value   (value_in),
			.left_value  (left_value),
			.left_ge     (left_ge),
			.right_value (right_value),
			.ge          (ge[i]),
			.value       (cell_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctrl.load) begin
				fill_q <= fill_q + 1'b1;
			end else if (ctrl.unload) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q <= '0;
			status_q    <= iss_pkg::STATUS_OK;
			last_q      <= 1'b0;
			if (action == iss_pkg::ACTION_LOAD) begin
				if (full) begin
					status_q <= iss_pkg::STATUS_FULL;
				end
			end else if (empty) begin
				status_q <= iss_pkg::STATUS_EMPTY;
			end else begin
				value_out_q <= cell_value[0];
				last_q      <= (fill_q == iss_pkg::CNT_W'(1));
			end
		end
	end

	assign done      = done_q;
	assign value_out = value_out_q;
	assign status    = status_q;
	assign last_out  = last_q;

`include "integer_sorting_store_assert.svh"

	`ISS_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= iss_pkg::CNT_W'(iss_pkg::CAPACITY))
	`ISS_ASSERT_NEXT(a_one_result, clk, arst_n, accept, done)
	`ISS_ASSERT_NEXT(a_last_unload, clk, arst_n, last_unload, last_out && empty)
	`ISS_ASSERT_NEXT(a_full_drop, clk, arst_n, full_load, full && (status == iss_pkg::STATUS_FULL))

endmodule

[rtl/iss_cell.sv]
module iss_cell (
	input  logic                                clk,
	input  iss_pkg::cell_ctrl_t                 ctrl,
	input  logic                                occ,
	input  logic signed [iss_pkg::DATA_W-1:0]   new_value,
	input  logic signed [iss_pkg::DATA_W-1:0]   left_value,
	input  logic                                left_ge,
	input  logic signed [iss_pkg::DATA_W-1:0]   right_value,
	output logic                                ge,
	output logic signed [iss_pkg::DATA_W-1:0]   value
);

	logic signed [iss_pkg::DATA_W-1:0] value_q;

	// An empty cell counts as larger than any value, so the insertion point is the
	// first cell whose flag is set while its left neighbour's is clear.
	assign ge    = !occ || (value_q > new_value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			if (ge && !left_ge) begin
				value_q <= new_value;
			end else if (ge) begin
				value_q <= left_value;
			end
		end else if (ctrl.unload) begin
			value_q <= right_value;
		end
	end

endmodule

[tb/sv/integer_sorting_store_tb.sv]
`timescale 1ns / 100ps

module integer_sorting_store_tb;
	import iss_pkg::*;

	localparam int CYCLE_LIMIT = 100000;

	typedef struct {
		logic                     act;
		logic signed [DATA_W-1:0] val;
		bit                       hold_for_drain;
	} sort_cmd_t;

	typedef struct {
		logic signed [DATA_W-1:0] val;
		logic [1:0]               stat;
		logic                     last;
	} sort_result_t;

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     start    = 1'b0;
	logic                     action   = ACTION_LOAD;
	logic signed [DATA_W-1:0] value_in = '0;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] value_out;
	logic [1:0]               status;
	logic                     last_out;

	sort_cmd_t                pending_cmds[$];
	sort_result_t             expected_results[$];
	logic signed [DATA_W-1:0] held_sorted[$];
	int                       plan_fill   = 0;
	int                       n_sent      = 0;
	int                       n_got       = 0;
	int                       fail_count  = 0;
	int                       cycle_count = 0;
	int                       idle_left   = 0;
	bit                       idle_on     = 1'b1;

	integer_sorting_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.action   (action),
		.value_in (value_in),
		.done     (done),
		.value_out(value_out),
		.status   (status),
		.last_out (last_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Keeps its own copy of the store in ascending order and returns the result of one command.
	function automatic sort_result_t apply_cmd(input logic act, input logic signed [DATA_W-1:0] v);
		sort_result_t r;
		int           pos;
		r.val  = '0;
		r.stat = STATUS_OK;
		r.last = 1'b0;
		if (act == ACTION_LOAD) begin
			if (held_sorted.size() >= CAPACITY) begin
				r.stat = STATUS_FULL;
			end else begin
				pos = held_sorted.size();
				while (pos > 0 && held_sorted[pos-1] > v)
					pos--;
				held_sorted.insert(pos, v);
			end
		end else if (held_sorted.size() == 0) begin
			r.stat = STATUS_EMPTY;
		end else begin
			r.val  = held_sorted.pop_front();
			r.last = (held_sorted.size() == 0);
		end
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] draw_value();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 3))
					0:       return 32'sh7FFFFFFF;
					1:       return 32'sh80000000;
					2:       return '0;
					default: return -32'sd1;
				endcase
			end
			1:       return $signed($urandom_range(0, 15)) - 32'sd8;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_cmd(input logic act, input logic signed [DATA_W-1:0] v, input bit hold);
		sort_cmd_t c;
		c.act            = act;
		c.val            = v;
		c.hold_for_drain = hold;
		pending_cmds.push_back(c);
		if (act == ACTION_LOAD && plan_fill < CAPACITY)
			plan_fill++;
		else if (act == ACTION_UNLOAD && plan_fill > 0)
			plan_fill--;
	endtask

	task automatic plan_mixed(input int count, input int load_pct);
		for (int i = 0; i < count; i++)
			queue_cmd(($urandom_range(0, 99) < load_pct) ? ACTION_LOAD : ACTION_UNLOAD,
				draw_value(), 1'b0);
	endtask

	task automatic plan_drain();
		bit first;
		first = 1'b1;
		while (plan_fill > 0) begin
			queue_cmd(ACTION_UNLOAD, draw_value(), first);
			first = 1'b0;
		end
		repeat (2) queue_cmd(ACTION_UNLOAD, draw_value(), 1'b0);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_commands
		sort_cmd_t                cmd;
		logic                     nxt_start;
		logic                     nxt_action;
		logic signed [DATA_W-1:0] nxt_value;
		logic                     xfer;
		if (!arst_n) begin
			start    <= 1'b0;
			action   <= ACTION_LOAD;
			value_in <= '0;
		end else begin
			nxt_start  = start;
			nxt_action = action;
			nxt_value  = value_in;
			xfer       = start && !busy;
			if (xfer) begin
				expected_results.push_back(apply_cmd(action, value_in));
				n_sent    <= n_sent + 1;
				nxt_start  = 1'b0;
				if ($urandom_range(0, 39) == 0)
					idle_on = !idle_on;
				idle_left = idle_on ? $urandom_range(0, 10) : 0;
			end
			if (!nxt_start) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (pending_cmds.size() != 0 && (!pending_cmds[0].hold_for_drain ||
						(!xfer && n_sent == n_got))) begin
					cmd        = pending_cmds.pop_front();
					nxt_start  = 1'b1;
					nxt_action = cmd.act;
					nxt_value  = cmd.val;
				end
			end
			start    <= nxt_start;
			action   <= nxt_action;
			value_in <= nxt_value;
		end
	end

	always @(posedge clk) begin : check_results
		sort_result_t want;
		if (arst_n && done) begin
			if (n_got == n_sent) begin
				fail_count++;
				if (fail_count <= 10)
					$display("Unexpected result: value_out %0d status %0d last_out %0b",
						value_out, status, last_out);
			end else begin
				want   = expected_results.pop_front();
				n_got <= n_got + 1;
				if (value_out !== want.val || status !== want.stat || last_out !== want.last) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Mismatch on transfer %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
							n_got, want.val, want.stat, want.last, value_out, status, last_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("integer_sorting_store test failed");
			$finish;
		end
	end

	initial begin
		queue_cmd(ACTION_UNLOAD, 32'sh12345678, 1'b0);
		queue_cmd(ACTION_LOAD, 32'sh7FFFFFFF, 1'b0);
		queue_cmd(ACTION_LOAD, 32'sh80000000, 1'b0);
		queue_cmd(ACTION_LOAD, 32'sd0, 1'b0);
		queue_cmd(ACTION_LOAD, -32'sd1, 1'b0);
		queue_cmd(ACTION_LOAD, 32'sd1, 1'b0);
		queue_cmd(ACTION_LOAD, 32'sd5, 1'b0);
		queue_cmd(ACTION_LOAD, 32'sd5, 1'b0);
		queue_cmd(ACTION_LOAD, -32'sd1, 1'b0);
		queue_cmd(ACTION_LOAD, 32'sh55555555, 1'b0);
		queue_cmd(ACTION_LOAD, 32'shAAAAAAAA, 1'b0);
		repeat (10) queue_cmd(ACTION_UNLOAD, 32'shFFFFFFFF, 1'b0);
		queue_cmd(ACTION_UNLOAD, 32'sh0, 1'b0);
		queue_cmd(ACTION_LOAD, 32'sh80000000, 1'b0);
		queue_cmd(ACTION_UNLOAD, 32'sh7FFFFFFF, 1'b0);

		// Random mix, fill past capacity, mix, drain past empty, a further mix and a last drain.
		plan_mixed(80, 60);
		begin : plan_fill_up
			bit first;
			first = 1'b1;
			while (plan_fill < CAPACITY) begin
				queue_cmd(ACTION_LOAD, draw_value(), first);
				first = 1'b0;
			end
			repeat (4) queue_cmd(ACTION_LOAD, draw_value(), 1'b0);
		end
		plan_mixed(30, 50);
		plan_drain();
		plan_mixed(60, 55);
		plan_drain();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (n_got != n_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (fail_count == 0 && expected_results.size() == 0)
			$display("integer_sorting_store test passed");
		else
			$display("integer_sorting_store test failed");
		$finish;
	end

endmodule
